// ===== hdl/lbm_pkg.sv =====
// shared types and constants for the label boundary marker block
`default_nettype none
package lbm_pkg;
  localparam logic [1:0] OP_WR_OFFSET = 2'd0;
  localparam logic [1:0] OP_WR_LABEL  = 2'd1;
  localparam logic [1:0] OP_SCAN      = 2'd2;
  localparam logic [1:0] OP_RESTART   = 2'd3;

  localparam logic [2:0] REG_SIZE_X   = 3'd0;
  localparam logic [2:0] REG_SIZE_Y   = 3'd1;
  localparam logic [2:0] REG_SIZE_Z   = 3'd2;
  localparam logic [2:0] REG_NBR_CNT  = 3'd3;
  localparam logic [2:0] REG_BORDER   = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  entry_index;
    logic [6:0]  offset_x;
    logic [6:0]  offset_y;
    logic [6:0]  offset_z;
    logic [17:0] voxel_address;
    logic [15:0] label_value;
  } in_item_t;

  typedef struct packed {
    logic [17:0] marker_address;
    logic        found;
    logic        scan_done;
    logic [18:0] marker_total;
  } out_item_t;

  typedef struct packed {
    logic [2:0] index;
    logic [6:0] value;
  } cfg_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic wr_offset;
    logic wr_label;
    logic restart;
    logic resync;       // rebuild coordinates from the linear position
    logic start_voxel;  // read label at scan position
    logic load_center;  // latch center label
    logic start_nbr;    // issue neighbor read for current entry
    logic check_nbr;    // compare neighbor label
    logic next_voxel;   // advance position
    logic hit;          // count marker and build result
    logic finish;       // build done result
  } cmd_t;

  typedef struct packed {
    logic stale;       // sizes changed since coordinates were derived
    logic resync_busy;
    logic at_end;      // position at or past volume end
    logic center_nil;
    logic border;
    logic nbr_last;    // no more neighbor entries
    logic nbr_valid;   // current neighbor is in bounds
    logic nbr_differs;
  } status_t;
endpackage
`default_nettype wire

// ===== hdl/lbm_if.sv =====
// valid/ready channel interfaces
`default_nettype none
interface lbm_in_if;
  logic valid;
  logic ready;
  lbm_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lbm_out_if;
  logic valid;
  logic ready;
  lbm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lbm_cfg_if;
  logic valid;
  logic ready;
  lbm_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/lbm_ram.sv =====
// generic single port ram with registered read
`default_nettype none
module lbm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== hdl/lbm_datapath.sv =====
// label boundary datapath: stores, coordinates, neighbor checks, result
`default_nettype none
module lbm_datapath #(
  parameter int MAX_DIM = 64,
  parameter int MAX_NEIGHBORS = 32,
  parameter int LABEL_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lbm_pkg::in_item_t in_data,
  input  wire lbm_pkg::cmd_t     cmd,
  input  wire logic              cfg_we,
  input  wire lbm_pkg::cfg_item_t cfg_data,
  output lbm_pkg::status_t       status,
  output lbm_pkg::out_item_t     result
);
  localparam int DB = $clog2(MAX_DIM);
  localparam int DW = DB + 1;
  localparam int AB = 3 * DB;
  localparam int NB = $clog2(MAX_NEIGHBORS);
  localparam int NW = NB + 1;
  localparam int CW = DW + 1;

  // config
  logic [DW-1:0] size_x, size_y, size_z;
  logic [NW-1:0] nbr_cnt;
  logic          border;

  function automatic logic [DW-1:0] clamp_dim(input logic [6:0] v);
    if (v == 7'd0) return DW'(1);
    if (32'(v) > MAX_DIM) return DW'(MAX_DIM);
    return DW'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= clamp_dim(7'd64);
      size_y <= clamp_dim(7'd64);
      size_z <= clamp_dim(7'd64);
      nbr_cnt <= '0;
      border <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_data.index)
        lbm_pkg::REG_SIZE_X: size_x <= clamp_dim(cfg_data.value);
        lbm_pkg::REG_SIZE_Y: size_y <= clamp_dim(cfg_data.value);
        lbm_pkg::REG_SIZE_Z: size_z <= clamp_dim(cfg_data.value);
        lbm_pkg::REG_NBR_CNT:
          nbr_cnt <= (32'(cfg_data.value[5:0]) > MAX_NEIGHBORS) ?
                     NW'(MAX_NEIGHBORS) : NW'(cfg_data.value[5:0]);
        lbm_pkg::REG_BORDER: border <= cfg_data.value[0];
        default: ;
      endcase
    end
  end

  // scan position: linear count plus coordinates in raster order
  logic [18:0]   scan_pos;
  logic [18:0]   vol_n;
  logic [DW-1:0] pos_x, pos_y, pos_z;
  logic [18:0]   marker_counter;
  logic          stale;
  logic [NW-1:0] entry;
  logic [LABEL_BITS-1:0] center;
  logic          nbr_ok;
  logic [20:0]   ofs_q;

  logic wrap_x, wrap_y;
  assign wrap_x = (pos_x + DW'(1)) >= size_x;
  assign wrap_y = (pos_y + DW'(1)) >= size_y;

  // restoring divider: x = p mod sx, then y = (p / sx) mod sy, z = p / (sx*sy)
  logic          dv_busy, dv_pass;
  logic [4:0]    dv_cnt;
  logic [DW-1:0] dv_rem;
  logic [18:0]   dv_quo;
  logic [DW-1:0] dv_div;
  logic [DW:0]   dv_trial, dv_rem_next;
  logic          dv_ge;
  logic [18:0]   dv_q_next;
  assign dv_div = dv_pass ? size_y : size_x;
  assign dv_trial = {dv_rem, dv_quo[18]};
  assign dv_ge = dv_trial >= {1'b0, dv_div};
  assign dv_rem_next = dv_ge ? dv_trial - {1'b0, dv_div} : dv_trial;
  assign dv_q_next = {dv_quo[17:0], dv_ge};

  // position at or past end under current sizes (handles shrink mid scan)
  assign status.at_end = scan_pos >= vol_n;
  assign status.stale = stale;
  assign status.resync_busy = dv_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0; pos_y <= '0; pos_z <= '0;
      scan_pos <= '0;
      marker_counter <= '0;
      stale <= 1'b0;
      dv_busy <= 1'b0;
      dv_pass <= 1'b0;
      dv_cnt <= '0;
      dv_rem <= '0;
      dv_quo <= '0;
    end else begin
      if (cfg_we && (cfg_data.index inside {lbm_pkg::REG_SIZE_X, lbm_pkg::REG_SIZE_Y,
                                            lbm_pkg::REG_SIZE_Z}))
        stale <= 1'b1;
      else if (dv_busy && dv_pass && dv_cnt == 5'd18) stale <= 1'b0;

      if (cmd.restart) begin
        pos_x <= '0; pos_y <= '0; pos_z <= '0;
        scan_pos <= '0;
        marker_counter <= '0;
      end else if (cmd.resync) begin
        dv_busy <= 1'b1;
        dv_pass <= 1'b0;
        dv_cnt <= '0;
        dv_rem <= '0;
        dv_quo <= scan_pos;
      end else if (dv_busy) begin
        if (dv_cnt == 5'd18) begin
          dv_cnt <= '0;
          dv_rem <= '0;
          if (!dv_pass) begin
            pos_x <= dv_rem_next[DW-1:0];
            dv_quo <= dv_q_next;
            dv_pass <= 1'b1;
          end else begin
            pos_y <= dv_rem_next[DW-1:0];
            pos_z <= dv_q_next[DW-1:0];
            dv_busy <= 1'b0;
          end
        end else begin
          dv_cnt <= dv_cnt + 5'd1;
          dv_rem <= dv_rem_next[DW-1:0];
          dv_quo <= dv_q_next;
        end
      end else begin
        if (cmd.next_voxel) begin
          scan_pos <= scan_pos + 19'd1;
          if (!wrap_x) pos_x <= pos_x + DW'(1);
          else begin
            pos_x <= '0;
            if (!wrap_y) pos_y <= pos_y + DW'(1);
            else begin
              pos_y <= '0;
              pos_z <= pos_z + DW'(1);
            end
          end
        end
        if (cmd.hit) marker_counter <= marker_counter + 19'd1;
      end
    end
  end

  // offset table
  logic [20:0] ofs_rd;
  logic ofs_we;
  logic [NB-1:0] ofs_addr;
  assign ofs_we = cmd.wr_offset && (32'(in_data.entry_index) < MAX_NEIGHBORS);
  assign ofs_addr = cmd.wr_offset ? NB'(in_data.entry_index) : entry[NB-1:0];
  lbm_ram #(.WIDTH(21), .DEPTH(MAX_NEIGHBORS)) u_ofs (
    .clk(clk), .we(ofs_we), .addr(ofs_addr),
    .wdata({in_data.offset_z, in_data.offset_y, in_data.offset_x}), .rdata(ofs_rd));

  // neighbor coordinates from the offset read
  logic signed [DW+1:0] vx, vy, vz;
  assign vx = $signed({2'b0, pos_x}) + (DW+2)'($signed(ofs_rd[6:0]));
  assign vy = $signed({2'b0, pos_y}) + (DW+2)'($signed(ofs_rd[13:7]));
  assign vz = $signed({2'b0, pos_z}) + (DW+2)'($signed(ofs_rd[20:14]));
  logic in_bounds;
  assign in_bounds = !vx[DW+1] && !vy[DW+1] && !vz[DW+1] &&
                     (vx[DW:0] < {1'b0, size_x}) && (vy[DW:0] < {1'b0, size_y}) &&
                     (vz[DW:0] < {1'b0, size_z});

  // label address: x + y*sx + z*sx*sy, each product computed into its own register
  logic [DB-1:0] ax, ay, az;
  logic [2*DB-1:0] y_sx;
  logic [2*DB:0] sxsy;
  logic [AB-1:0] z_sxsy;
  logic [DB-1:0] rx, rz;
  logic [LABEL_BITS-1:0] lab_rd;

  // entry advances when its neighbor read is issued, so the next offset
  // is read out by the time the neighbor label is checked
  always_ff @(posedge clk) begin
    if (cmd.start_voxel) begin
      ax <= pos_x[DB-1:0]; ay <= pos_y[DB-1:0]; az <= pos_z[DB-1:0];
      entry <= NW'(1);
    end else if (cmd.start_nbr) begin
      ax <= vx[DB-1:0]; ay <= vy[DB-1:0]; az <= vz[DB-1:0];
      nbr_ok <= in_bounds;
      ofs_q <= ofs_rd;
      entry <= entry + NW'(1);
    end
    sxsy <= (2*DB+1)'(size_x * size_y);
    vol_n <= 19'(sxsy * size_z);
    y_sx <= (2*DB)'(ay * size_x);
    z_sxsy <= AB'(az * sxsy);
    rx <= ax;
    rz <= az;
    if (cmd.load_center) center <= lab_rd;
  end

  logic [AB-1:0] lab_addr;
  assign lab_addr = cmd.wr_label ? AB'(in_data.voxel_address) :
                    AB'(rx) + AB'(y_sx) + z_sxsy;
  logic lab_we;
  assign lab_we = cmd.wr_label && (32'(in_data.voxel_address) < MAX_DIM*MAX_DIM*MAX_DIM);
  logic [LABEL_BITS-1:0] lab_wd;
  assign lab_wd = LABEL_BITS'(32'($signed(in_data.label_value)));
  lbm_ram #(.WIDTH(LABEL_BITS), .DEPTH(MAX_DIM*MAX_DIM*MAX_DIM)) u_lab (
    .clk(clk), .we(lab_we), .addr(lab_addr), .wdata(lab_wd), .rdata(lab_rd));

  assign status.center_nil = (lab_rd == {LABEL_BITS{1'b1}});
  assign status.border = border;
  assign status.nbr_last = entry >= nbr_cnt;
  assign status.nbr_valid = nbr_ok;
  assign status.nbr_differs = lab_rd != center;

  // the marker address is the linear position of the current voxel
  always_ff @(posedge clk) begin
    if (cmd.hit) begin
      result.marker_address <= scan_pos[17:0];
      result.found <= 1'b1;
      result.scan_done <= 1'b0;
      result.marker_total <= marker_counter + 19'd1;
    end else if (cmd.finish) begin
      result.marker_address <= '0;
      result.found <= 1'b0;
      result.scan_done <= 1'b1;
      result.marker_total <= marker_counter;
    end
  end

  logic unused;
  assign unused = ^{ofs_q, rz, cmd.check_nbr, in_data.operation, dv_rem_next[DW],
                    scan_pos[18], CW'(0)};
endmodule
`default_nettype wire

// ===== hdl/lbm_ctrl.sv =====
// scan controller state machine
`default_nettype none
module lbm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_op,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire lbm_pkg::status_t  status,
  output lbm_pkg::cmd_t          cmd
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHK   = 10'b0000000010,
    S_CA    = 10'b0000000100,  // address pipe
    S_CB    = 10'b0000001000,
    S_CR    = 10'b0000010000,  // center label ready
    S_NO    = 10'b0000100000,  // issue neighbor read
    S_NA    = 10'b0001000000,
    S_NB    = 10'b0010000000,
    S_NR    = 10'b0100000000,
    S_DIV   = 10'b1000000000   // coordinates rebuilt after a size change
  } state_t;

  state_t state, state_next;
  logic out_full;

  assign in_ready = (state == S_IDLE) && !out_full;
  assign out_valid = out_full;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: if (in_valid && in_ready) begin
        case (in_op)
          lbm_pkg::OP_WR_OFFSET: cmd.wr_offset = 1'b1;
          lbm_pkg::OP_WR_LABEL:  cmd.wr_label = 1'b1;
          lbm_pkg::OP_RESTART:   cmd.restart = 1'b1;
          default: state_next = S_CHK;
        endcase
      end
      S_CHK: if (status.stale) begin
        cmd.resync = 1'b1; state_next = S_DIV;
      end else if (status.at_end) begin
        cmd.finish = 1'b1; state_next = S_IDLE;
      end else begin
        cmd.start_voxel = 1'b1; state_next = S_CA;
      end
      S_DIV: if (!status.resync_busy) state_next = S_CHK;
      S_CA: state_next = S_CB;
      S_CB: state_next = S_CR;
      S_CR: begin
        cmd.load_center = 1'b1;
        if (status.center_nil || (status.border && status.nbr_last)) begin
          cmd.next_voxel = 1'b1; state_next = S_CHK;
        end else if (!status.border) begin
          cmd.hit = 1'b1; cmd.next_voxel = 1'b1; state_next = S_IDLE;
        end else state_next = S_NO;
      end
      S_NO: begin cmd.start_nbr = 1'b1; state_next = S_NA; end
      S_NA: state_next = S_NB;
      S_NB: state_next = S_NR;
      S_NR: begin
        cmd.check_nbr = 1'b1;
        if (status.nbr_valid && status.nbr_differs) begin
          cmd.hit = 1'b1; cmd.next_voxel = 1'b1; state_next = S_IDLE;
        end else if (status.nbr_last) begin
          cmd.next_voxel = 1'b1; state_next = S_CHK;
        end else state_next = S_NO;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.hit || cmd.finish) out_full <= 1'b1;
      else if (out_ready) out_full <= 1'b0;
    end
  end

  a_onecmd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.hit && cmd.finish)) else $error("hit and finish together");
  a_noover: assert property (@(posedge clk) disable iff (rst)
    (cmd.hit || cmd.finish) |-> !out_full) else $error("result overwritten");
  a_idle_rdy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
endmodule
`default_nettype wire

// ===== hdl/label_boundary_markers.sv =====
// top level of the label boundary marker scanner
// label_boundary_markers: scans a 3d label volume for marker voxels
//
// channels: in (operation items), out (scan results), cfg (register writes)
// write offset, write label and restart give no result
// scan next walks from the scan position: each voxel reads the center label,
// plus, in border mode, a neighbor label per adjacency entry after entry 0 until one differs,
// since the single port label ram serves the center and each neighbor in turn
// through a two stage address multiply; one result item per scan next
// the result register is loaded on the last cycle of the walk and offered
// on the next; the first scan after a size write first rebuilds x, y, z
// from the linear position (two 19 step divides)
// a new item is taken only after the previous result has been delivered,
// so a stalled receiver holds the block
// reset: sizes 64, no neighbors, border mode on, scan position and count zero
// label and offset stores are not cleared; unwritten entries read anything
`default_nettype none
module label_boundary_markers #(
  parameter int MAX_DIM = 64,
  parameter int MAX_NEIGHBORS = 32,
  parameter int LABEL_BITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  lbm_in_if.sink   in,
  lbm_out_if.source out,
  lbm_cfg_if.sink  cfg
);
  lbm_pkg::cmd_t    cmd;
  lbm_pkg::status_t status;

  // config always accepted
  assign cfg.ready = 1'b1;

  lbm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in.valid), .in_op(in.data.operation),
    .in_ready(in.ready), .out_valid(out.valid), .out_ready(out.ready),
    .status(status), .cmd(cmd));

  lbm_datapath #(.MAX_DIM(MAX_DIM), .MAX_NEIGHBORS(MAX_NEIGHBORS),
                 .LABEL_BITS(LABEL_BITS)) u_dp (
    .clk(clk), .rst(rst), .in_data(in.data), .cmd(cmd),
    .cfg_we(cfg.valid), .cfg_data(cfg.data), .status(status), .result(out.data));
endmodule
`default_nettype wire

// ===== bench/lbm_test_if.sv =====
// no content of its own: the channel interfaces come from the rtl, this file keeps the folder order
`timescale 1ns / 100ps

// ===== bench/label_boundary_markers_test.sv =====
// self-checking testbench for the label boundary marker scanner
`timescale 1ns / 100ps
module label_boundary_markers_test;
  localparam int STORE_WORDS = 262144;
  localparam int TABLE_WORDS = 32;
  localparam logic [15:0] NIL = 16'hFFFF;
  localparam int RANDOM_ITEMS = 380;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lbm_in_if  in_ch();
  lbm_out_if out_ch();
  lbm_cfg_if cfg_ch();

  label_boundary_markers dut (
    .clk(clk),
    .rst(rst),
    .in(in_ch),
    .out(out_ch),
    .cfg(cfg_ch)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the scanner state
  logic [15:0] label_mem [STORE_WORDS];
  logic [20:0] nbr_table [TABLE_WORDS];
  logic [18:0] scan_pos;
  logic [18:0] mark_cnt;
  int vol_x, vol_y, vol_z, nbr_cnt;
  logic border_on;

  // results still owed by the block, oldest first
  lbm_pkg::out_item_t owed_results[$];
  int mismatches = 0;
  int snd_pct = 0;
  int rcv_pct = 0;
  int items_sent = 0;

  // one row of the directed table: a register write or an item,
  // with an optional typed result for scan items
  typedef struct {
    bit        is_cfg;
    logic [2:0] reg_idx;
    logic [6:0] reg_val;
    lbm_pkg::in_item_t  item;
    bit        typed;
    lbm_pkg::out_item_t result;
  } row_t;

  function automatic int clamp_dim(logic [6:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [6:0] val);
    case (idx)
      lbm_pkg::REG_SIZE_X: vol_x = clamp_dim(val);
      lbm_pkg::REG_SIZE_Y: vol_y = clamp_dim(val);
      lbm_pkg::REG_SIZE_Z: vol_z = clamp_dim(val);
      lbm_pkg::REG_NBR_CNT: nbr_cnt = (val[5:0] > 32) ? 32 : int'(val[5:0]);
      lbm_pkg::REG_BORDER: border_on = val[0];
      default: ;
    endcase
  endfunction

  // does voxel p count as a marker under the current settings
  function automatic bit is_marker(int p);
    logic [15:0] lab;
    logic [20:0] e;
    int x, y, z, vx, vy, vz, q;
    lab = label_mem[p];
    if (lab == NIL) return 1'b0;
    if (!border_on) return 1'b1;
    x = p % vol_x;
    y = (p / vol_x) % vol_y;
    z = p / (vol_x * vol_y);
    for (int k = 1; k < nbr_cnt; k++) begin
      e = nbr_table[k];
      vx = x + int'($signed(e[6:0]));
      vy = y + int'($signed(e[13:7]));
      vz = z + int'($signed(e[20:14]));
      if (vx < 0 || vy < 0 || vz < 0) continue;
      if (vx >= vol_x || vy >= vol_y || vz >= vol_z) continue;
      q = vx + vy * vol_x + vz * vol_x * vol_y;
      if (label_mem[q] != lab) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic lbm_pkg::out_item_t next_marker();
    lbm_pkg::out_item_t r;
    int n, p;
    r = '0;
    n = vol_x * vol_y * vol_z;
    while (int'(scan_pos) < n) begin
      p = int'(scan_pos);
      scan_pos = scan_pos + 1;
      if (is_marker(p)) begin
        mark_cnt = mark_cnt + 1;
        r.marker_address = p[17:0];
        r.found = 1'b1;
        r.marker_total = mark_cnt;
        return r;
      end
    end
    r.scan_done = 1'b1;
    r.marker_total = mark_cnt;
    return r;
  endfunction

  // update the shadow state for one item; returns 1 with the result for a scan
  function automatic bit track_item(lbm_pkg::in_item_t it, output lbm_pkg::out_item_t r);
    r = '0;
    case (it.operation)
      lbm_pkg::OP_WR_OFFSET:
        nbr_table[it.entry_index] = {it.offset_z, it.offset_y, it.offset_x};
      lbm_pkg::OP_WR_LABEL: label_mem[it.voxel_address] = it.label_value;
      lbm_pkg::OP_RESTART: begin
        scan_pos = '0;
        mark_cnt = '0;
      end
      default: begin
        r = next_marker();
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // drive one item; returns once the block has accepted it
  task automatic send_item(lbm_pkg::in_item_t it, bit typed, lbm_pkg::out_item_t typed_res);
    lbm_pkg::out_item_t r;
    bit gives;
    if (snd_pct > 0 && $urandom_range(99) < snd_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    gives = track_item(it, r);
    if (gives) owed_results.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  // sender pauses until every owed result is back and the block has settled
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // register write while idle; valid stays high across back to back writes
  task automatic write_reg(logic [2:0] idx, logic [6:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.value <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, val);
  endtask

  function automatic lbm_pkg::in_item_t mk(logic [1:0] op);
    lbm_pkg::in_item_t it;
    it = '0;
    it.operation = op;
    return it;
  endfunction

  function automatic lbm_pkg::in_item_t mk_label(int addr, logic [15:0] lab);
    lbm_pkg::in_item_t it;
    it = mk(lbm_pkg::OP_WR_LABEL);
    it.voxel_address = addr[17:0];
    it.label_value = lab;
    return it;
  endfunction

  function automatic lbm_pkg::in_item_t mk_offset(int idx, int ox, int oy, int oz);
    lbm_pkg::in_item_t it;
    it = mk(lbm_pkg::OP_WR_OFFSET);
    it.entry_index = idx[4:0];
    it.offset_x = ox[6:0];
    it.offset_y = oy[6:0];
    it.offset_z = oz[6:0];
    return it;
  endfunction

  // few distinct labels so borders are common, with nil and extremes
  function automatic logic [15:0] pick_label();
    int r;
    r = $urandom_range(99);
    if (r < 20) return NIL;
    if (r < 80) return 16'($urandom_range(3));
    if (r < 88) return 16'h7FFF;
    return 16'($urandom_range(32767));
  endfunction

  // mostly short displacements, sometimes far ones that leave the volume
  function automatic int pick_disp();
    if ($urandom_range(9) == 0) return $urandom_range(126) - 63;
    return $urandom_range(4) - 2;
  endfunction

  // result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    lbm_pkg::out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: addr %0d found %0b done %0b total %0d",
            out_ch.data.marker_address, out_ch.data.found, out_ch.data.scan_done,
            out_ch.data.marker_total);
      end else begin
        want = owed_results.pop_front();
        if (out_ch.data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected addr %0d found %0b done %0b total %0d,",
                      " got addr %0d found %0b done %0b total %0d"},
              want.marker_address, want.found, want.scan_done, want.marker_total,
              out_ch.data.marker_address, out_ch.data.found, out_ch.data.scan_done,
              out_ch.data.marker_total);
        end
      end
    end
  end

  // receiver side back pressure
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= (rcv_pct == 0) || ($urandom_range(99) >= rcv_pct);
  end

  // hard stop for a hung block
  initial begin
    #200000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t rw;
    lbm_pkg::out_item_t none;
    lbm_pkg::in_item_t it;
    int phase, nvox, nops, r;
    logic [6:0] rx, ry, rz;

    none = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    scan_pos = '0;
    mark_cnt = '0;
    vol_x = 64;
    vol_y = 64;
    vol_z = 64;
    nbr_cnt = 0;
    border_on = 1'b1;
    for (int i = 0; i < TABLE_WORDS; i++) nbr_table[i] = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole adjacency table so every entry is defined before use
    for (int i = 0; i < TABLE_WORDS; i++)
      send_item(mk_offset(i, pick_disp(), pick_disp(), pick_disp()), 1'b0, none);
    drain();

    // directed table: tiny 2x1x1 volume, saturating register values
    rw = '{default: '0};
    rw.is_cfg = 1; rw.reg_idx = lbm_pkg::REG_SIZE_X;  rw.reg_val = 7'd2;   rows.push_back(rw);
    rw.reg_idx = lbm_pkg::REG_SIZE_Y;  rw.reg_val = 7'd0;   rows.push_back(rw);
    rw.reg_idx = lbm_pkg::REG_SIZE_Z;  rw.reg_val = 7'd0;   rows.push_back(rw);
    rw.reg_idx = lbm_pkg::REG_NBR_CNT; rw.reg_val = 7'd63;  rows.push_back(rw);
    rw.reg_idx = lbm_pkg::REG_BORDER;  rw.reg_val = 7'd0;   rows.push_back(rw);
    rw = '{default: '0};
    rw.item = mk_label(0, 16'd5);  rows.push_back(rw);
    rw.item = mk_label(1, NIL);    rows.push_back(rw);
    // all-labels mode: first voxel found, then done, then done again after the end
    rw.item = mk(lbm_pkg::OP_SCAN); rw.typed = 1;
    rw.result = '{marker_address: 18'd0, found: 1'b1, scan_done: 1'b0, marker_total: 19'd1};
    rows.push_back(rw);
    rw.result = '{marker_address: 18'd0, found: 1'b0, scan_done: 1'b1, marker_total: 19'd1};
    rows.push_back(rw);
    rows.push_back(rw);
    rw = '{default: '0};
    rw.item = mk(lbm_pkg::OP_RESTART); rows.push_back(rw);
    rw.item = mk(lbm_pkg::OP_SCAN); rw.typed = 1;
    rw.result = '{marker_address: 18'd0, found: 1'b1, scan_done: 1'b0, marker_total: 19'd1};
    rows.push_back(rw);
    rw = '{default: '0};
    // extreme offsets and extreme address and label values
    rw.item = mk_offset(31, -63, 63, 0);      rows.push_back(rw);
    rw.item = mk_offset(1, 1, 0, 0);          rows.push_back(rw);
    rw.item = mk_label(262143, 16'h7FFF);     rows.push_back(rw);
    rw.item = mk_label(1, 16'h7FFF);          rows.push_back(rw);
    rw = '{default: '0};
    rw.is_cfg = 1; rw.reg_idx = lbm_pkg::REG_BORDER; rw.reg_val = 7'd1; rows.push_back(rw);
    rw = '{default: '0};
    rw.item = mk(lbm_pkg::OP_RESTART); rows.push_back(rw);
    rw.item = mk(lbm_pkg::OP_SCAN); rows.push_back(rw);
    rows.push_back(rw);
    rows.push_back(rw);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
        cfg_ch.valid <= 1'b0;
      end else begin
        send_item(rows[i].item, rows[i].typed, rows[i].result);
      end
    end
    drain();

    // random phases: new settings, fill the volume, then mostly scans
    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain();
      case (phase % 4)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 59; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 59; end
        default: begin snd_pct = 20; rcv_pct = 20; end
      endcase
      // one long axis at the top size now and then, else small volumes
      case (phase % 6)
        0: begin rx = 7'd64; ry = 7'd1; rz = 7'd0; end
        1: begin rx = 7'd1; ry = 7'd127; rz = 7'd1; end
        2: begin rx = 7'd0; ry = 7'd1; rz = 7'd64; end
        default: begin
          rx = 7'($urandom_range(1, 5));
          ry = 7'($urandom_range(1, 4));
          rz = 7'($urandom_range(1, 3));
        end
      endcase
      write_reg(lbm_pkg::REG_SIZE_X, rx);
      write_reg(lbm_pkg::REG_SIZE_Y, ry);
      write_reg(lbm_pkg::REG_SIZE_Z, rz);
      write_reg(lbm_pkg::REG_NBR_CNT, 7'($urandom_range(63)));
      write_reg(lbm_pkg::REG_BORDER, 7'($urandom_range(99) < 75));
      cfg_ch.valid <= 1'b0;

      // every voxel of the new volume gets a label before the walk reads it;
      // without a restart the walk carries on under the new sizes
      nvox = vol_x * vol_y * vol_z;
      for (int a = 0; a < nvox; a++) send_item(mk_label(a, pick_label()), 1'b0, none);
      if ($urandom_range(1)) send_item(mk(lbm_pkg::OP_RESTART), 1'b0, none);

      nops = $urandom_range(20, 40);
      for (int k = 0; k < nops; k++) begin
        r = $urandom_range(99);
        if (r < 62) it = mk(lbm_pkg::OP_SCAN);
        else if (r < 72) it = mk_label($urandom_range(nvox - 1), pick_label());
        else if (r < 78) it = mk_label($urandom_range(STORE_WORDS - 1), 16'($urandom));
        else if (r < 86)
          it = mk_offset($urandom_range(31), pick_disp(), pick_disp(), pick_disp());
        else if (r < 92) it = mk(lbm_pkg::OP_RESTART);
        else begin
          // noise in the fields an operation does not use
          it = lbm_pkg::in_item_t'(62'({$urandom, $urandom}));
          if (it.operation == lbm_pkg::OP_WR_LABEL)
            it.voxel_address = 18'($urandom_range(nvox - 1));
        end
        send_item(it, 1'b0, none);
      end
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== label_boundary_markers.f =====
hdl/lbm_pkg.sv
hdl/lbm_if.sv
hdl/lbm_ram.sv
hdl/lbm_datapath.sv
hdl/lbm_ctrl.sv
hdl/label_boundary_markers.sv
bench/lbm_test_if.sv
bench/label_boundary_markers_test.sv
